// ----- rtl/srfc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the sensor reply frame checker.
// No dependencies; every other file of the block imports this package.
package srfc_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FUNC_RESET = 8'h03;
    localparam logic [7:0]  LEN_RESET  = 8'h02;

    // Configuration register indexes.
    localparam logic [7:0] CFG_EXP_FUNCTION = 8'd0;
    localparam logic [7:0] CFG_EXP_LENGTH   = 8'd1;

    // Position of a byte inside the six-byte reply frame.
    localparam logic [2:0] BYTE_FUNC   = 3'd0;
    localparam logic [2:0] BYTE_LEN    = 3'd1;
    localparam logic [2:0] BYTE_HUM_HI = 3'd2;
    localparam logic [2:0] BYTE_HUM_LO = 3'd3;
    localparam logic [2:0] BYTE_CRC_LO = 3'd4;
    localparam logic [2:0] BYTE_CRC_HI = 3'd5;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FUNC = 2'd1,
        ST_LEN  = 2'd2,
        ST_CRC  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] exp_function;
        logic [7:0] exp_length;
    } cfg_t;

    typedef struct packed {
        logic [15:0] humidity;
        status_t     status;
    } result_t;

    // One byte of a reflected CRC-16, unrolled over its eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/srfc_cfg_regs.sv -----
// Configuration registers of the sensor reply frame checker: expected function and length.
// Depends on srfc_pkg.
module srfc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [7:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output srfc_pkg::cfg_t cfg
);
    import srfc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXP_FUNCTION: cfg_next.exp_function = cfg_data;
                CFG_EXP_LENGTH:   cfg_next.exp_length   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exp_function <= FUNC_RESET;
            cfg_reg.exp_length   <= LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/srfc_frame_core.sv -----
// Frame tracking of the sensor reply frame checker: byte count, CRC, captured fields, verdict.
// Depends on srfc_pkg.
module srfc_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       rx_byte,
    input  logic             frame_start,
    input  srfc_pkg::cfg_t   cfg,
    output logic             res_valid,
    output srfc_pkg::result_t res
);
    import srfc_pkg::*;

    logic [2:0]  idx_reg,      idx_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  func_reg,     func_next;
    logic [7:0]  len_reg,      len_next;
    logic [15:0] hum_reg,      hum_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;

    logic [2:0]  idx_eff;
    logic [15:0] crc_got;
    status_t     st;

    // A start flag forces byte zero; unused index codes fall into the default arm.
    assign idx_eff = frame_start ? BYTE_FUNC : idx_reg;
    assign crc_got = {rx_byte, crc_lo_reg};

    always_comb
    begin
        if (func_reg != cfg.exp_function)
        begin
            st = ST_FUNC;
        end
        else if (len_reg != cfg.exp_length)
        begin
            st = ST_LEN;
        end
        else if (crc_got != crc_reg)
        begin
            st = ST_CRC;
        end
        else
        begin
            st = ST_OK;
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        hum_next    = hum_reg;
        crc_lo_next = crc_lo_reg;
        res_valid   = 1'b0;
        res.humidity = (st == ST_OK) ? hum_reg : 16'h0000;
        res.status   = st;
        if (advance)
        begin
            case (idx_eff)
                BYTE_LEN:
                begin
                    crc_next = crc_byte(crc_reg, rx_byte);
                    len_next = rx_byte;
                    idx_next = BYTE_HUM_HI;
                end
                BYTE_HUM_HI:
                begin
                    crc_next = crc_byte(crc_reg, rx_byte);
                    hum_next = {rx_byte, 8'h00};
                    idx_next = BYTE_HUM_LO;
                end
                BYTE_HUM_LO:
                begin
                    crc_next = crc_byte(crc_reg, rx_byte);
                    hum_next = {hum_reg[15:8], rx_byte};
                    idx_next = BYTE_CRC_LO;
                end
                BYTE_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    idx_next    = BYTE_CRC_HI;
                end
                BYTE_CRC_HI:
                begin
                    res_valid = 1'b1;
                    crc_next  = CRC_INIT;
                    idx_next  = BYTE_FUNC;
                end
                default:
                begin
                    crc_next  = crc_byte(CRC_INIT, rx_byte);
                    func_next = rx_byte;
                    idx_next  = BYTE_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= BYTE_FUNC;
            crc_reg    <= CRC_INIT;
            func_reg   <= 8'h00;
            len_reg    <= 8'h00;
            hum_reg    <= 16'h0000;
            crc_lo_reg <= 8'h00;
        end
        else
        begin
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            func_reg   <= func_next;
            len_reg    <= len_next;
            hum_reg    <= hum_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

// ----- rtl/srfc_out_reg.sv -----
// Result register of the sensor reply frame checker, decoupling the output handshake.
// Depends on srfc_pkg.
module srfc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  srfc_pkg::result_t res,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata
);
    import srfc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg,  data_next;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, data_reg.status, data_reg.humidity};

endmodule

// ----- rtl/sensor_reply_frame_check_unit.sv -----
// Top level of the sensor reply frame checker: stream ports, config port, submodules.
// Depends on srfc_pkg, srfc_cfg_regs, srfc_frame_core and srfc_out_reg.
// Each result is registered; m_tvalid rises the cycle after its sixth frame byte is taken.
// Throughput: one byte per cycle outside input stalls, set by the unrolled CRC byte update.
// Input stalls only while a held result is not taken by the downstream side.
// Reset (rst_n low, asynchronous) restores expected function 3, length 2, and byte zero.
module sensor_reply_frame_check_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input bytes of the reply frame.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    // Frame results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] humidity, [17:16] status, [23:18] zero
    // Configuration writes; always accepted.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import srfc_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    space;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign s_tready  = space;
    // A byte is taken whenever the result register has room for what it may produce.
    assign advance   = s_tvalid && space;

    srfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srfc_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    srfc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/srfc_checker.sv -----
// Port-level checks for the sensor reply frame checker, bound to its top level.
// Depends on srfc_pkg and sensor_reply_frame_check_unit.
module srfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import srfc_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Any error status reports a zero humidity.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:16] == ST_OK) || (m_tdata[15:0] == 16'h0000))
        else $error("nonzero humidity with error status");

    // Input is held off while a result is stuck.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    // A start byte never produces a result.
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !m_tvalid)
        else $error("result after frame start byte");

endmodule

bind sensor_reply_frame_check_unit srfc_checker u_srfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_sensor_reply_frame_check_unit.sv -----
// Self-checking testbench for the sensor reply frame checker: directed frames, then random
// frame streams under several register settings. Depends only on srfc_pkg and the block.
`timescale 1ns / 1ps

module tb_sensor_reply_frame_check_unit;

    import srfc_pkg::*;

    // Register indexes from 2 upward exist on the port but are ignored by the block.
    localparam logic [7:0] CFG_FIRST_UNUSED = 8'd2;

    // Cycles to let pass after the last expected result before touching the registers
    // or ending the run; the block answers in the cycle after the sixth byte.
    localparam int DRAIN_SLACK     = 4;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_BYTES     = 380;
    localparam int CYCLE_LIMIT     = 200000;

    // How a directed row gets its byte: as written, or from the running checksum so that
    // a clean frame does not need a hand-computed CRC.
    typedef enum logic [1:0] {
        ROW_RAW,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CRC_FLIP
    } row_kind_t;

    // One byte of stimulus. Where has_want is set, the result that this byte closes is
    // checked against want_hum and want_status instead of the predictor's answer.
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        row_kind_t   kind;
        logic        has_want;
        logic [15:0] want_hum;
        status_t     want_status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;

    sensor_reply_frame_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a copy of the frame tracker and of the two registers.
    logic [2:0]  frame_pos;
    logic [15:0] crc_run;
    logic [7:0]  func_byte;
    logic [7:0]  len_byte;
    logic [15:0] hum_word;
    logic [7:0]  crc_lo_byte;
    logic [7:0]  exp_func;
    logic [7:0]  exp_len;

    // Frame results still owed by the block, oldest first.
    result_t     frame_results_due[$];
    stim_row_t   byte_stream[$];

    // Frame position as the random generator sees it, so that it knows when a frame
    // may start without the start flag.
    int          gen_pos;
    int          idle_max;
    bit          hold_off_request;
    int          error_count;
    int          cycle_count;
    result_t     got_want;

    // The directed part. A frame cut short by a new start flag and then sent clean;
    // function and length both wrong, where the function check must win; a wrong
    // length sent with no start flag right after a completed frame; a checksum that
    // is off by one bit. FF is sent as function, length and data bytes, 00 as length.
    stim_row_t directed_rows [26] = '{
        '{8'h03, 1'b1, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h02, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h03, 1'b1, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h02, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hAA, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h55, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_CRC_LO,   1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_CRC_HI,   1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b1, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h12, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h34, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_RAW,      1'b1, 16'h0000, ST_FUNC},
        '{8'h03, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'hFF, 1'b0, ROW_RAW,      1'b1, 16'h0000, ST_LEN},
        '{8'h03, 1'b1, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h02, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h80, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h01, 1'b0, ROW_RAW,      1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_CRC_FLIP, 1'b0, 16'h0000, ST_OK},
        '{8'h00, 1'b0, ROW_CRC_HI,   1'b1, 16'h0000, ST_CRC}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Reflected CRC-16 over one byte, low bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic reset_frame_model();
        frame_pos   = BYTE_FUNC;
        crc_run     = CRC_INIT;
        func_byte   = 8'h00;
        len_byte    = 8'h00;
        hum_word    = 16'h0000;
        crc_lo_byte = 8'h00;
        exp_func    = FUNC_RESET;
        exp_len     = LEN_RESET;
    endtask

    // Advances the frame tracker by one accepted byte. Only the sixth byte of a frame
    // yields a result; the checks are taken function first, then length, then checksum,
    // and the humidity is zeroed on any error.
    task automatic predict_frame_byte(input logic [7:0] b, input logic start,
                                      output logic has_result, output result_t res);
        has_result   = 1'b0;
        res.humidity = 16'h0000;
        res.status   = ST_OK;
        if (start || frame_pos > BYTE_CRC_HI)
        begin
            frame_pos = BYTE_FUNC;
            crc_run   = CRC_INIT;
        end
        case (frame_pos)
            BYTE_FUNC:
            begin
                crc_run   = crc16_step(CRC_INIT, b);
                func_byte = b;
                frame_pos = BYTE_LEN;
            end
            BYTE_LEN:
            begin
                crc_run   = crc16_step(crc_run, b);
                len_byte  = b;
                frame_pos = BYTE_HUM_HI;
            end
            BYTE_HUM_HI:
            begin
                crc_run   = crc16_step(crc_run, b);
                hum_word  = {b, 8'h00};
                frame_pos = BYTE_HUM_LO;
            end
            BYTE_HUM_LO:
            begin
                crc_run       = crc16_step(crc_run, b);
                hum_word[7:0] = b;
                frame_pos     = BYTE_CRC_LO;
            end
            BYTE_CRC_LO:
            begin
                crc_lo_byte = b;
                frame_pos   = BYTE_CRC_HI;
            end
            default:
            begin
                if (func_byte != exp_func)
                begin
                    res.status = ST_FUNC;
                end
                else if (len_byte != exp_len)
                begin
                    res.status = ST_LEN;
                end
                else if ({b, crc_lo_byte} != crc_run)
                begin
                    res.status = ST_CRC;
                end
                res.humidity = (res.status == ST_OK) ? hum_word : 16'h0000;
                has_result   = 1'b1;
                frame_pos    = BYTE_FUNC;
                crc_run      = CRC_INIT;
            end
        endcase
    endtask

    // Random stream building. queue_byte keeps gen_pos in step with the block's count.
    task automatic queue_byte(input logic [7:0] b, input logic start);
        stim_row_t row;
        row = '{b, start, ROW_RAW, 1'b0, 16'h0000, ST_OK};
        byte_stream.push_back(row);
        if (start || gen_pos > BYTE_CRC_HI)
        begin
            gen_pos = BYTE_FUNC;
        end
        gen_pos = (gen_pos == BYTE_CRC_HI) ? BYTE_FUNC : gen_pos + 1;
    endtask

    // A whole frame. The start flag is optional when the count is already at byte zero,
    // and required otherwise so that the frame is not swallowed by a partial one.
    task automatic queue_frame(input logic [7:0] f, input logic [7:0] l,
                               input logic [15:0] hum, input logic [15:0] crc_mask);
        logic [15:0] c;
        logic        start;
        c = crc16_step(crc16_step(crc16_step(crc16_step(CRC_INIT, f), l), hum[15:8]),
                       hum[7:0]) ^ crc_mask;
        start = (gen_pos == BYTE_FUNC) ? 1'($urandom_range(0, 1)) : 1'b1;
        queue_byte(f, start);
        queue_byte(l, 1'b0);
        queue_byte(hum[15:8], 1'b0);
        queue_byte(hum[7:0], 1'b0);
        queue_byte(c[7:0], 1'b0);
        queue_byte(c[15:8], 1'b0);
    endtask

    // Mostly clean frames that reach the humidity output, some with a defect, and
    // some short bursts of noise with stray start flags that break frames apart.
    task automatic queue_random_frames(input int byte_budget);
        int target;
        int pick;
        int burst;
        target = byte_stream.size() + byte_budget;
        while (byte_stream.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                queue_frame(exp_func, exp_len, 16'($urandom), 16'h0000);
            end
            else if (pick < 73)
            begin
                queue_frame(exp_func ^ 8'($urandom_range(1, 255)),
                            8'($urandom), 16'($urandom), 16'h0000);
            end
            else if (pick < 81)
            begin
                queue_frame(exp_func, exp_len ^ 8'($urandom_range(1, 255)),
                            16'($urandom), 16'h0000);
            end
            else if (pick < 88)
            begin
                queue_frame(exp_func, exp_len, 16'($urandom),
                            16'($urandom_range(1, 65535)));
            end
            else
            begin
                burst = $urandom_range(1, 5);
                repeat (burst) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Sends everything queued, one byte per handshake, with a random gap before each.
    // Entered and left at a falling edge. The expected result is booked at the edge
    // where the byte is taken.
    task automatic send_items();
        stim_row_t   row;
        int          gap;
        logic        has_result;
        result_t     res;
        logic [7:0]  drive_byte;
        while (byte_stream.size() > 0)
        begin
            row = byte_stream.pop_front();
            gap = $urandom_range(0, idle_max);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            case (row.kind)
                ROW_CRC_LO:   drive_byte = crc_run[7:0];
                ROW_CRC_HI:   drive_byte = crc_run[15:8];
                ROW_CRC_FLIP: drive_byte = crc_run[7:0] ^ 8'h01;
                default:      drive_byte = row.data;
            endcase
            s_tdata  = drive_byte;
            s_tuser  = row.start;
            s_tvalid = 1'b1;
            do @(posedge clk); while (!s_tready);
            predict_frame_byte(drive_byte, row.start, has_result, res);
            if (has_result)
            begin
                frame_results_due.push_back(row.has_want ? result_t'{row.want_hum,
                                                                     row.want_status}
                                                         : res);
            end
            @(negedge clk);
        end
        s_tvalid = 1'b0;
    endtask

    // The sender pauses here until every owed result has come back, then lets the
    // DRAIN_SLACK margin run out before going on.
    task automatic wait_results_drained();
        while (frame_results_due.size() != 0) @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // One register write. Only called while the block is idle, so the predictor's copy
    // can be updated at the handshake.
    task automatic write_register(input logic [7:0] index, input logic [7:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (index == CFG_EXP_FUNCTION)
        begin
            exp_func = value;
        end
        else if (index == CFG_EXP_LENGTH)
        begin
            exp_len = value;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Result receiver. Before each result it may stall for a random time; on request it
    // holds off for a long stretch so that the block fills up and stalls its input.
    initial
    begin : result_receiver
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_request = 1'b0;
            end
            stall = $urandom_range(0, idle_max);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Result checker: each taken result against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("unexpected result: humidity %h, status %0d",
                       m_tdata[15:0], m_tdata[17:16]);
                error_count++;
            end
            else
            begin
                got_want = frame_results_due.pop_front();
                if (m_tdata[15:0] !== got_want.humidity)
                begin
                    $error("humidity: expected %h, actual %h",
                           got_want.humidity, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[17:16] !== got_want.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           got_want.status, m_tdata[17:16]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sensor_reply_frame_check_unit: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'h00;
        s_tuser          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = 8'h00;
        cfg_data         = 8'h00;
        idle_max         = 4;
        hold_off_request = 1'b0;
        error_count      = 0;
        cycle_count      = 0;
        gen_pos          = BYTE_FUNC;
        reset_frame_model();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames against the reset values of the registers.
        foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
        send_items();

        // Lowest register values, with a long hold-off on the result side while bytes
        // keep coming.
        wait_results_drained();
        write_register(CFG_EXP_FUNCTION, 8'h00);
        write_register(CFG_EXP_LENGTH, 8'h00);
        queue_random_frames(PHASE_BYTES);
        hold_off_request = 1'b1;
        send_items();

        // Highest register values and a write to an unused index; no idling at all.
        wait_results_drained();
        write_register(CFG_EXP_FUNCTION, 8'hFF);
        write_register(CFG_EXP_LENGTH, 8'hFF);
        write_register(8'($urandom_range(CFG_FIRST_UNUSED, 255)), 8'($urandom));
        idle_max = 0;
        queue_random_frames(PHASE_BYTES);
        send_items();

        // Random register values with idling on both sides.
        wait_results_drained();
        write_register(CFG_EXP_FUNCTION, 8'($urandom));
        write_register(CFG_EXP_LENGTH, 8'($urandom));
        idle_max = 4;
        queue_random_frames(PHASE_BYTES);
        send_items();

        // Back to the reset values, another unused index, another long hold-off.
        wait_results_drained();
        write_register(8'($urandom_range(CFG_FIRST_UNUSED, 255)), 8'($urandom));
        write_register(CFG_EXP_FUNCTION, FUNC_RESET);
        write_register(CFG_EXP_LENGTH, LEN_RESET);
        queue_random_frames(PHASE_BYTES);
        hold_off_request = 1'b1;
        send_items();

        wait_results_drained();
        if (error_count == 0)
        begin
            $display("tb_sensor_reply_frame_check_unit: done, clean");
        end
        else
        begin
            $display("tb_sensor_reply_frame_check_unit: done, errors");
        end
        $finish;
    end

endmodule
